// ===== hw/rtl/b64d_pkg.sv =====
// Shared types and constants of the base64 stream decoder.
// Used by the front, the group queue, the back and the top level; depends on nothing.
package b64d_pkg;

  localparam int unsigned GroupBytes        = 3;
  localparam int unsigned QueueDepthDefault = 4;

  // Up to three decoded bytes from one input word; bytes[0] leaves first.
  typedef struct packed {
    logic [GroupBytes-1:0][7:0] bytes;
    logic [1:0]                 count;
  } group_t;

  typedef struct packed {
    logic       stopped;
    logic [1:0] count;
  } front_status_t;

endpackage

// ===== hw/rtl/b64d_front.sv =====
// Front of the base64 stream decoder: maps each character, keeps the partial group
// and turns accepted words into groups of decoded bytes. Depends on b64d_pkg.
module b64d_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              symbol_i,
  input  logic                    final_req_i,
  output logic                    wr_o,
  output b64d_pkg::group_t        grp_o,
  output b64d_pkg::front_status_t status_o
);
  import b64d_pkg::*;

  localparam logic [7:0] SymNul = 8'h00;
  localparam logic [7:0] SymPad = 8'h3d;

  logic [17:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        stopped_q, stopped_d;
  logic [5:0]  sym_val;
  logic        is_term;
  logic [23:0] full_word;
  group_t      grp;

  function automatic logic [5:0] map_symbol(input logic [7:0] c);
    logic [5:0] v;
    v = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      v = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      v = 6'd62;
    end else if (c == 8'h2f) begin
      v = 6'd63;
    end
    return v;
  endfunction

  // A partial group is flushed left-aligned; a single value yields no byte.
  function automatic group_t flush_partial(input logic [17:0] acc, input logic [1:0] cnt);
    group_t g;
    g = '0;
    unique case (cnt)
      2'd2: begin
        g.bytes[0] = acc[11:4];
        g.count    = 2'd1;
      end
      2'd3: begin
        g.bytes[0] = acc[17:10];
        g.bytes[1] = acc[9:2];
        g.count    = 2'd2;
      end
      default: g = '0;
    endcase
    return g;
  endfunction

  assign sym_val   = map_symbol(symbol_i);
  assign is_term   = (symbol_i == SymNul) || (symbol_i == SymPad);
  assign full_word = {acc_q, sym_val};

  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    stopped_d = stopped_q;
    grp       = '0;
    if (!stopped_q) begin
      if (is_term) begin
        grp       = flush_partial(acc_q, cnt_q);
        acc_d     = '0;
        cnt_d     = '0;
        stopped_d = 1'b1;
      end else if (cnt_q == 2'd3) begin
        grp.bytes[0] = full_word[23:16];
        grp.bytes[1] = full_word[15:8];
        grp.bytes[2] = full_word[7:0];
        grp.count    = 2'd3;
        acc_d        = '0;
        cnt_d        = '0;
      end else begin
        acc_d = {acc_q[11:0], sym_val};
        cnt_d = cnt_q + 2'd1;
      end
    end
    if (final_req_i) begin
      if (grp.count == 2'd0) begin
        grp = flush_partial(acc_d, cnt_d);
      end
      acc_d     = '0;
      cnt_d     = '0;
      stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      cnt_q     <= '0;
      stopped_q <= 1'b0;
    end else if (accept_i) begin
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      stopped_q <= stopped_d;
    end
  end

  assign wr_o     = accept_i && (grp.count != 2'd0);
  assign grp_o    = grp;
  assign status_o = '{stopped: stopped_q, count: cnt_q};

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// Short queue of byte groups between the front and the back of the decoder.
// Depends on b64d_pkg for the group type.
module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  b64d_pkg::group_t wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output b64d_pkg::group_t rd_data_o,
  output logic             empty_o
);
  import b64d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   fill_q, fill_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o    = (fill_q == CntW'(Depth));
  assign empty_o   = (fill_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q;
    if (wr_i && !rd_i) begin
      fill_d = fill_q + CntW'(1);
    end else if (rd_i && !wr_i) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// Back of the base64 stream decoder: takes byte groups from the queue and hands
// them out one byte per word from an output register. Depends on b64d_pkg.
module b64d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  b64d_pkg::group_t q_data_i,
  input  logic             q_empty_i,
  output logic             q_rd_o,
  output logic [7:0]       data_byte_o,
  output logic             run_last_o,
  output logic             empty_o,
  input  logic             pop_i
);
  import b64d_pkg::*;

  group_t     grp_q;
  logic [1:0] idx_q;
  logic       valid_q;
  logic       last;
  logic       take;
  logic       free;

  assign last   = (idx_q + 2'd1) == grp_q.count;
  assign take   = pop_i && valid_q;
  assign free   = !valid_q || (take && last);
  assign q_rd_o = free && !q_empty_i;

  always_comb begin
    unique case (idx_q)
      2'd0:    data_byte_o = grp_q.bytes[0];
      2'd1:    data_byte_o = grp_q.bytes[1];
      2'd2:    data_byte_o = grp_q.bytes[2];
      default: data_byte_o = '0;
    endcase
  end

  assign run_last_o = last;
  assign empty_o    = !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take && last) begin
      valid_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      grp_q <= q_data_i;
    end
  end

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// Top level of the base64 stream decoder: front, group queue and back.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Characters enter as words on the push/full side: one word is taken at a rising
// edge with push high and full low, and one can be taken in every cycle.
// Decoded bytes leave on the empty/pop side, oldest first; a byte is taken at a
// rising edge with pop high and empty low. run_last_o marks the last byte that
// one character produced. A character yields zero to three bytes.
// A byte reaches the outputs through the group queue and then the back's output
// register; the output side delivers one byte per cycle while pop is high and the
// queue holds groups. Input throughput is one character per cycle as long as its
// average yield stays at or below one byte; otherwise the group queue between front
// and back (QueueDepth groups) fills and full rises. When the receiver stalls, the
// pending byte holds on the outputs, the queue fills and then full holds off the
// sender. Reset clears the partial group, rearms decoding and empties the queue.
module base64_stream_decoder #(
  parameter int unsigned QueueDepth = b64d_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] symbol_i,
  input  logic       final_req_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic       run_last_o
);
  import b64d_pkg::*;

  logic          accept;
  logic          q_wr;
  group_t        q_wr_data;
  logic          q_full;
  logic          q_rd;
  group_t        q_rd_data;
  logic          q_empty;
  front_status_t front_status;

  assign accept = push && !q_full;
  assign full   = q_full;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .symbol_i    (symbol_i),
    .final_req_i (final_req_i),
    .wr_o        (q_wr),
    .grp_o       (q_wr_data),
    .status_o    (front_status)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_rd_data),
    .empty_o   (q_empty)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (q_rd_data),
    .q_empty_i   (q_empty),
    .q_rd_o      (q_rd),
    .data_byte_o (data_byte_o),
    .run_last_o  (run_last_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  a_stopped_no_partial : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_status.stopped |-> (front_status.count == 2'd0))
    else $error("decoder stopped with a partial group held");

  a_final_rearms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && final_req_i) |=> (!front_status.stopped && (front_status.count == 2'd0)))
    else $error("final word did not rearm the decoder");

  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !run_last_o) |=> !empty)
    else $error("byte run broken before its last byte");

  a_queue_read_safe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> !q_empty)
    else $error("group queue read while empty");

endmodule
